// ----- hw/rtl/wcf_pkg.sv -----
// shared types and constants of the wheel command frame parser
`default_nettype none

package wcf_pkg;

    // status reported with every byte
    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_ERROR = 2'd1,
        ST_DONE  = 2'd2
    } status_t;

    // position within the frame, one-hot
    typedef enum logic [6:0] {
        POS_MOTOR    = 7'b000_0001,
        POS_ACTION   = 7'b000_0010,
        POS_REF_HI   = 7'b000_0100,
        POS_REF_LO   = 7'b000_1000,
        POS_TICK_HI  = 7'b001_0000,
        POS_TICK_LO  = 7'b010_0000,
        POS_CHECKSUM = 7'b100_0000
    } pos_t;

    // legal ranges of the motor and action bytes
    localparam logic [7:0] MOTOR_MIN  = 8'h01;
    localparam logic [7:0] MOTOR_MAX  = 8'h04;
    localparam logic [7:0] ACTION_MIN = 8'h01;
    localparam logic [7:0] ACTION_MAX = 8'h03;

    // byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_stage_t;

    // one result
    typedef struct packed {
        status_t     status;
        logic [2:0]  motor_id;
        logic [1:0]  action_code;
        logic [15:0] reference_value;
        logic [15:0] tick_limit;
        logic [7:0]  frame_checksum;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wcf_stream_if.sv -----
// request channel interfaces: received bytes in, parser results out
`default_nettype none

interface wcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wcf_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  motor_id;
    logic [1:0]  action_code;
    logic [15:0] reference_value;
    logic [15:0] tick_limit;
    logic [7:0]  frame_checksum;

    modport source (output valid, output status, output motor_id, output action_code,
                    output reference_value, output tick_limit, output frame_checksum,
                    input ready);
    modport sink   (input valid, input status, input motor_id, input action_code,
                    input reference_value, input tick_limit, input frame_checksum,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wcf_input_stage.sv -----
// input register: holds one received byte until the decoder takes it
`default_nettype none

module wcf_input_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire logic [7:0]          cmd_byte,
    output logic                     cmd_ready,
    input  wire logic                advance,
    output wcf_pkg::byte_stage_t     stage
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // free when empty or when the held byte moves on this cycle
    assign cmd_ready = !valid_reg || advance;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_valid && cmd_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // byte payload
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            data_reg <= cmd_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wcf_frame_decoder.sv -----
// frame state and per-byte decode: position, held fields, running checksum
`default_nettype none

module wcf_frame_decoder (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            advance,
    output wcf_pkg::result_t     res
);

    wcf_pkg::pos_t pos_reg, pos_next;
    logic [2:0]    motor_reg, motor_next;
    logic [1:0]    action_reg, action_next;
    logic [15:0]   ref_reg, ref_next;
    logic [15:0]   tick_reg, tick_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    sum_add;
    logic          restart;

    assign sum_add = sum_reg + rx_byte;

    // decode of the current byte against the frame position
    always_comb
    begin
        pos_next    = pos_reg;
        motor_next  = motor_reg;
        action_next = action_reg;
        ref_next    = ref_reg;
        tick_next   = tick_reg;
        sum_next    = sum_add;
        restart     = 1'b0;
        res         = '0;
        res.status  = wcf_pkg::ST_BUSY;

        case (pos_reg)
            wcf_pkg::POS_MOTOR:
            begin
                pos_next = wcf_pkg::POS_ACTION;
                if (rx_byte inside {[wcf_pkg::MOTOR_MIN:wcf_pkg::MOTOR_MAX]})
                begin
                    motor_next = rx_byte[2:0];
                end
                else
                begin
                    res.status = wcf_pkg::ST_ERROR;
                    restart    = 1'b1;
                end
            end
            wcf_pkg::POS_ACTION:
            begin
                pos_next = wcf_pkg::POS_REF_HI;
                if (rx_byte inside {[wcf_pkg::ACTION_MIN:wcf_pkg::ACTION_MAX]})
                begin
                    action_next = rx_byte[1:0];
                end
                else
                begin
                    res.status = wcf_pkg::ST_ERROR;
                    restart    = 1'b1;
                end
            end
            wcf_pkg::POS_REF_HI:
            begin
                pos_next = wcf_pkg::POS_REF_LO;
                ref_next = {rx_byte, 8'h00};
            end
            wcf_pkg::POS_REF_LO:
            begin
                pos_next = wcf_pkg::POS_TICK_HI;
                ref_next = {ref_reg[15:8], rx_byte};
            end
            wcf_pkg::POS_TICK_HI:
            begin
                pos_next  = wcf_pkg::POS_TICK_LO;
                tick_next = {rx_byte, 8'h00};
            end
            wcf_pkg::POS_TICK_LO:
            begin
                pos_next  = wcf_pkg::POS_CHECKSUM;
                tick_next = {tick_reg[15:8], rx_byte};
            end
            default:
            begin
                // checksum byte: frame ends either way
                restart = 1'b1;
                if (sum_add == 8'h00)
                begin
                    res.status          = wcf_pkg::ST_DONE;
                    res.motor_id        = motor_reg;
                    res.action_code     = action_reg;
                    res.reference_value = ref_reg;
                    res.tick_limit      = tick_reg;
                    res.frame_checksum  = rx_byte;
                end
                else
                begin
                    res.status = wcf_pkg::ST_ERROR;
                end
            end
        endcase

        // back to waiting for a motor byte
        if (restart)
        begin
            pos_next    = wcf_pkg::POS_MOTOR;
            motor_next  = '0;
            action_next = '0;
            ref_next    = '0;
            tick_next   = '0;
            sum_next    = '0;
        end
    end

    // frame state update, once per byte taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= wcf_pkg::POS_MOTOR;
            motor_reg  <= '0;
            action_reg <= '0;
            ref_reg    <= '0;
            tick_reg   <= '0;
            sum_reg    <= '0;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            motor_reg  <= motor_next;
            action_reg <= action_next;
            ref_reg    <= ref_next;
            tick_reg   <= tick_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wcf_result_stage.sv -----
// result register and the handshake that moves a byte through the decoder
`default_nettype none

module wcf_result_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 stage_valid,
    input  wire wcf_pkg::result_t     res,
    output logic                      advance,
    wcf_result_if.source              result
);

    logic             valid_reg;
    wcf_pkg::result_t res_reg;

    // a byte is decoded when the result register is free or being emptied
    assign advance = stage_valid && (!valid_reg || result.ready);

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid           = valid_reg;
    assign result.status          = res_reg.status;
    assign result.motor_id        = res_reg.motor_id;
    assign result.action_code     = res_reg.action_code;
    assign result.reference_value = res_reg.reference_value;
    assign result.tick_limit      = res_reg.tick_limit;
    assign result.frame_checksum  = res_reg.frame_checksum;

endmodule

`default_nettype wire

// ----- hw/rtl/wheel_command_frame_parser.sv -----
// Wheel command frame parser. Takes one received byte per request on cmd and
// returns one result per byte on result: in progress, error (parser restarts)
// or frame complete with motor, action, reference, tick limit and checksum.
// A frame is motor (1..4), action (1..3), reference high/low, tick limit
// high/low and a checksum making the seven-byte sum zero modulo 256. The block
// sustains one byte per cycle while results are accepted; a taken byte is held
// in the input register, then decoded into the result register, which offers
// it. The decoder between the two registers updates the frame state per byte.
`default_nettype none

module wheel_command_frame_parser (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wcf_byte_if.sink      cmd,
    wcf_result_if.source  result
);

    wcf_pkg::byte_stage_t stage;
    wcf_pkg::result_t     res;
    logic                 advance;

    wcf_input_stage u_input (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_byte  (cmd.rx_byte),
        .cmd_ready (cmd.ready),
        .advance   (advance),
        .stage     (stage)
    );

    wcf_frame_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (stage.data),
        .advance (advance),
        .res     (res)
    );

    wcf_result_stage u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage.valid),
        .res         (res),
        .advance     (advance),
        .result      (result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/wcf_checker.sv -----
// port-level checks of the wheel command frame parser, bound to the top level
`default_nettype none

module wcf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  status,
    input wire logic [2:0]  motor_id,
    input wire logic [1:0]  action_code,
    input wire logic [15:0] reference_value,
    input wire logic [15:0] tick_limit,
    input wire logic [7:0]  frame_checksum
);

    // only the three defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == wcf_pkg::ST_BUSY || status == wcf_pkg::ST_ERROR ||
                       status == wcf_pkg::ST_DONE))
        else $error("undefined status code");

    // fields are zero unless a frame completes
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status != wcf_pkg::ST_DONE) |->
            (motor_id == 3'd0 && action_code == 2'd0 && reference_value == 16'd0 &&
             tick_limit == 16'd0 && frame_checksum == 8'd0))
        else $error("fields set on a result that is not complete");

    // a completed frame carries a legal motor and action
    a_done_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status == wcf_pkg::ST_DONE) |->
            (motor_id >= 3'd1 && motor_id <= 3'd4 &&
             action_code >= 2'd1 && action_code <= 2'd3))
        else $error("completed frame with illegal motor or action");

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result withdrawn while stalled");

endmodule

bind wheel_command_frame_parser wcf_checker u_wcf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .status          (result.status),
    .motor_id        (result.motor_id),
    .action_code     (result.action_code),
    .reference_value (result.reference_value),
    .tick_limit      (result.tick_limit),
    .frame_checksum  (result.frame_checksum)
);

`default_nettype wire

// ----- test/wcf_frame_checker.sv -----
// checker that predicts the parser result of every byte request and compares it
`default_nettype none

module wcf_frame_checker
    import wcf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    wcf_byte_if       cmd,
    wcf_result_if     result,
    output int        mismatch_count,
    output int        pending_results,
    output int        frames_done,
    output int        frame_errors
);

    // frame being assembled by the predictor
    pos_t        frame_pos;
    logic [2:0]  frame_motor;
    logic [1:0]  frame_action;
    logic [15:0] frame_reference;
    logic [15:0] frame_ticks;
    logic [7:0]  frame_sum;

    // predicted results, oldest first
    result_t expected_results[$];

    int n_bad;
    int n_done;
    int n_err;
    int n_results;

    task automatic clear_frame();
        frame_pos       = POS_MOTOR;
        frame_motor     = '0;
        frame_action    = '0;
        frame_reference = '0;
        frame_ticks     = '0;
        frame_sum       = '0;
    endtask

    // one byte through the frame state, giving the result it should produce
    task automatic parse_byte(input logic [7:0] b, output result_t r);
        logic advance;
        r        = '0;
        r.status = ST_BUSY;
        advance  = 1'b1;
        case (frame_pos)
            POS_MOTOR:
            begin
                if (b >= MOTOR_MIN && b <= MOTOR_MAX)
                    frame_motor = b[2:0];
                else
                    advance = 1'b0;
            end
            POS_ACTION:
            begin
                if (b >= ACTION_MIN && b <= ACTION_MAX)
                    frame_action = b[1:0];
                else
                    advance = 1'b0;
            end
            POS_REF_HI:
                frame_reference = {b, 8'h00};
            POS_REF_LO:
                frame_reference = {frame_reference[15:8], b};
            POS_TICK_HI:
                frame_ticks = {b, 8'h00};
            POS_TICK_LO:
                frame_ticks = {frame_ticks[15:8], b};
            default:
            begin
                // checksum byte: the seven-byte sum must wrap to zero
                advance = 1'b0;
                if (8'(frame_sum + b) == 8'h00)
                begin
                    r.status          = ST_DONE;
                    r.motor_id        = frame_motor;
                    r.action_code     = frame_action;
                    r.reference_value = frame_reference;
                    r.tick_limit      = frame_ticks;
                    r.frame_checksum  = b;
                end
            end
        endcase
        if (advance)
        begin
            frame_sum = frame_sum + b;
            frame_pos = pos_t'(frame_pos << 1);
        end
        else
        begin
            if (r.status != ST_DONE)
                r.status = ST_ERROR;
            clear_frame();
        end
    endtask

    // watch both channels on every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            clear_frame();
            expected_results.delete();
            n_bad           = 0;
            n_done          = 0;
            n_err           = 0;
            n_results       = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
            frames_done     <= 0;
            frame_errors    <= 0;
        end
        else
        begin
            // byte taken: predict its result
            if (cmd.valid && cmd.ready)
            begin
                parse_byte(cmd.rx_byte, want);
                expected_results.push_back(want);
            end
            // result taken: compare with the oldest prediction
            if (result.valid && result.ready)
            begin
                got.status          = status_t'(result.status);
                got.motor_id        = result.motor_id;
                got.action_code     = result.action_code;
                got.reference_value = result.reference_value;
                got.tick_limit      = result.tick_limit;
                got.frame_checksum  = result.frame_checksum;
                if (expected_results.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result %0d arrived with no prediction waiting, status %0d",
                                 n_results, got.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status == ST_DONE)
                        n_done++;
                    else if (want.status == ST_ERROR)
                        n_err++;
                    if (got !== want)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"result %0d wrong (expected/actual): status %0d/%0d",
                                      " motor %0d/%0d action %0d/%0d ref %h/%h",
                                      " ticks %h/%h checksum %h/%h"},
                                     n_results, want.status, got.status,
                                     want.motor_id, got.motor_id,
                                     want.action_code, got.action_code,
                                     want.reference_value, got.reference_value,
                                     want.tick_limit, got.tick_limit,
                                     want.frame_checksum, got.frame_checksum);
                    end
                end
                n_results++;
            end
            mismatch_count  <= n_bad;
            pending_results <= expected_results.size();
            frames_done     <= n_done;
            frame_errors    <= n_err;
        end
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// top of the parser testbench: clock, reset, byte and result stimulus, verdict
`default_nettype none

module testbench;
    import wcf_pkg::*;

    localparam int N_BYTES = 1950;

    logic clk;
    logic rst_n;
    logic burst_mode;
    int   bytes_sent;
    int   longest_hold;
    int   mismatch_count;
    int   pending_results;
    int   frames_done;
    int   frame_errors;

    wcf_byte_if   cmd_if();
    wcf_result_if res_if();

    wheel_command_frame_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if)
    );

    wcf_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_if),
        .result          (res_if),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .frames_done     (frames_done),
        .frame_errors    (frame_errors)
    );

    // clock, period 10
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // 16-bit field value with the extremes now and then
    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h0000;
        else if (r == 1)
            return 16'hFFFF;
        else
            return 16'($urandom);
    endfunction

    // offer one byte request and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.rx_byte <= b;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // whole seven-byte frame, checksum right or deliberately off
    task automatic send_frame(input logic [7:0] motor, input logic [7:0] action,
                              input logic [15:0] ref_w, input logic [15:0] ticks,
                              input logic good);
        logic [7:0] sum;
        logic [7:0] chk;
        sum = motor + action + ref_w[15:8] + ref_w[7:0] + ticks[15:8] + ticks[7:0];
        chk = 8'h00 - sum;
        if (!good)
            chk = chk + 8'($urandom_range(1, 255));
        send_byte(motor);
        send_byte(action);
        send_byte(ref_w[15:8]);
        send_byte(ref_w[7:0]);
        send_byte(ticks[15:8]);
        send_byte(ticks[7:0]);
        send_byte(chk);
    endtask

    // result side: random stalls, quiet stretches and long hold-offs
    initial
    begin : result_drain
        int hold;
        int cycle_no;
        int free_left;
        int r;
        hold         = 0;
        cycle_no     = 0;
        free_left    = 0;
        longest_hold = 0;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 6000 == 1500)
            begin
                // long hold-off so the parser fills and pushes back on its input
                hold         = 249;
                longest_hold = 250;
                res_if.ready <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
                res_if.ready <= 1'b0;
            end
            else if (free_left > 0)
            begin
                free_left--;
                res_if.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    free_left    = $urandom_range(100, 400);
                    res_if.ready <= 1'b1;
                end
                else if (r < 70)
                    res_if.ready <= 1'b1;
                else
                begin
                    hold = pick_gap();
                    if (hold > longest_hold)
                        longest_hold = hold;
                    res_if.ready <= (hold == 0);
                    if (hold > 0)
                        hold--;
                end
            end
        end
    end

    // byte stimulus and verdict
    initial
    begin : stimulus
        int kind;
        int next_mode_at;
        cmd_if.valid   <= 1'b0;
        cmd_if.rx_byte <= 8'h00;
        rst_n          <= 1'b0;
        bytes_sent   = 0;
        burst_mode   = 1'b0;
        next_mode_at = 150;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, bad checksum, out-of-range motor and action
        send_frame(MOTOR_MIN, ACTION_MIN, 16'h0000, 16'h0000, 1'b1);
        send_frame(MOTOR_MAX, ACTION_MAX, 16'hFFFF, 16'hFFFF, 1'b1);
        send_frame(8'h02, 8'h02, 16'h8001, 16'h7FFE, 1'b0);
        send_byte(8'h00);
        send_byte(MOTOR_MAX + 8'h01);
        send_byte(8'h03);
        send_byte(8'h00);

        // random: mostly well-formed frames, some broken ones and noise
        while (bytes_sent < N_BYTES)
        begin
            if (bytes_sent >= next_mode_at)
            begin
                burst_mode   = ($urandom_range(0, 3) == 0);
                next_mode_at = next_mode_at + 150;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)
                send_frame(8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                           pick_word(), pick_word(), $urandom_range(0, 9) != 0);
            else if (kind < 80)
            begin
                send_byte(8'($urandom_range(1, 4)));
                send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(4, 255)));
            end
            else if (kind < 85)
                send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(5, 255)));
            else
                send_byte(8'($urandom));
        end
        cmd_if.valid <= 1'b0;

        // drain: wait until every prediction is answered
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d bytes: %0d completed frames, %0d error results,",
                 bytes_sent, frames_done, frame_errors);
        $display("with result stalls of up to %0d cycles.", longest_hold);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/wcf_pkg.sv
hw/rtl/wcf_stream_if.sv
hw/rtl/wcf_input_stage.sv
hw/rtl/wcf_frame_decoder.sv
hw/rtl/wcf_result_stage.sv
hw/rtl/wheel_command_frame_parser.sv
hw/rtl/wcf_checker.sv
test/wcf_frame_checker.sv
test/testbench.sv
